>>> hdl/pstpa_pkg.sv
// ----------------------------------------------------------------------------
// pstpa_pkg: shared types and constants for the prefix-sum tree
// Field widths, stream packing offsets, item kinds and the back-end states.
// ----------------------------------------------------------------------------
package pstpa_pkg;

  localparam int DEFAULT_SIZE = 1024;

  localparam int POS_W  = 11;
  localparam int DATA_W = 64;

  // Slave tdata packing, lowest bit first: position, delta, range_left, range_right
  localparam int POS_LSB    = 0;
  localparam int DELTA_LSB  = POS_LSB + POS_W;
  localparam int LEFT_LSB   = DELTA_LSB + DATA_W;
  localparam int RIGHT_LSB  = LEFT_LSB + POS_W;
  localparam int IN_BITS    = RIGHT_LSB + POS_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_TDATA_W = DATA_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_QUERY,
    ST_OUT
  } state_e;

  // Command handed from front to back (walk indexes travel separately)
  typedef struct packed {
    kind_e              kind;
    logic [DATA_W-1:0]  delta;
  } cmd_t;

  // Back-end status seen by the front
  typedef struct packed {
    logic clearing;
  } status_t;

endpackage

>>> hdl/pstpa_ram.sv
// ----------------------------------------------------------------------------
// pstpa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pstpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/pstpa_front.sv
// ----------------------------------------------------------------------------
// pstpa_front: item intake and classification
// Unpacks items, drops adds that touch nothing, saturates query bounds and
// queues commands for the back end.
// ----------------------------------------------------------------------------
module pstpa_front #(
  parameter int SIZE = pstpa_pkg::DEFAULT_SIZE,
  localparam int IdxBits = $clog2(SIZE + 1),
  localparam int WalkW   = ((IdxBits > pstpa_pkg::POS_W) ? IdxBits : pstpa_pkg::POS_W) + 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [pstpa_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                                  s_axis_tuser_i,
  input  pstpa_pkg::status_t                    status_i,
  output logic                                  cmd_valid_o,
  input  logic                                  cmd_ready_i,
  output pstpa_pkg::cmd_t                       cmd_o,
  output logic [WalkW-1:0]                      cmd_idx_a_o,
  output logic [WalkW-1:0]                      cmd_idx_b_o
);

  localparam logic [WalkW-1:0] SizeW = WalkW'(SIZE);

  pstpa_pkg::kind_e             kind;
  logic [WalkW-1:0]             pos_w, left_w, right_w, right_sat, left_m1, lower_sat;
  logic [pstpa_pkg::DATA_W-1:0] delta;
  logic                         accept, keep, push, pop;
  logic [WalkW-1:0]             idx_a, idx_b;

  pstpa_pkg::cmd_t              cmd_q   [pstpa_pkg::QUEUE_DEPTH];
  logic [WalkW-1:0]             idx_a_q [pstpa_pkg::QUEUE_DEPTH];
  logic [WalkW-1:0]             idx_b_q [pstpa_pkg::QUEUE_DEPTH];
  logic [pstpa_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pstpa_pkg::QCNT_W-1:0] count_q, count_d;

  // Unpack and classify
  always_comb begin
    kind    = pstpa_pkg::kind_e'(s_axis_tuser_i);
    pos_w   = WalkW'(s_axis_tdata_i[pstpa_pkg::POS_LSB +: pstpa_pkg::POS_W]);
    delta   = s_axis_tdata_i[pstpa_pkg::DELTA_LSB +: pstpa_pkg::DATA_W];
    left_w  = WalkW'(s_axis_tdata_i[pstpa_pkg::LEFT_LSB +: pstpa_pkg::POS_W]);
    right_w = WalkW'(s_axis_tdata_i[pstpa_pkg::RIGHT_LSB +: pstpa_pkg::POS_W]);

    right_sat = (right_w > SizeW) ? SizeW : right_w;
    left_m1   = left_w - WalkW'(1);
    lower_sat = (left_w == '0) ? '0 : ((left_m1 > SizeW) ? SizeW : left_m1);

    keep = 1'b1;
    unique case (kind)
      pstpa_pkg::KIND_ADD: begin
        idx_a = pos_w;
        idx_b = '0;
        keep  = (pos_w != '0) && (pos_w <= SizeW);
      end
      pstpa_pkg::KIND_QUERY: begin
        idx_a = right_sat;
        idx_b = lower_sat;
      end
      default: begin
        idx_a = '0;
        idx_b = '0;
      end
    endcase
  end

  assign s_axis_tready_o = (count_q < pstpa_pkg::QCNT_W'(pstpa_pkg::QUEUE_DEPTH))
                           && !status_i.clearing;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign push   = accept && keep;
  assign pop    = cmd_valid_o && cmd_ready_i;

  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign cmd_idx_a_o = idx_a_q[rd_ptr_q];
  assign cmd_idx_b_o = idx_b_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + pstpa_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + pstpa_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + pstpa_pkg::QCNT_W'(push) - pstpa_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q]   <= '{kind: kind, delta: delta};
      idx_a_q[wr_ptr_q] <= idx_a;
      idx_b_q[wr_ptr_q] <= idx_b;
    end
  end

endmodule

>>> hdl/pstpa_back.sv
// ----------------------------------------------------------------------------
// pstpa_back: tree walk engine
// Clears the partial-sum store after reset, then walks lowest-set-bit chains
// for adds and prefix queries, at most one store read and write per cycle.
// ----------------------------------------------------------------------------
module pstpa_back #(
  parameter int SIZE = pstpa_pkg::DEFAULT_SIZE,
  localparam int IdxBits = $clog2(SIZE + 1),
  localparam int WalkW   = ((IdxBits > pstpa_pkg::POS_W) ? IdxBits : pstpa_pkg::POS_W) + 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cmd_valid_i,
  output logic                                  cmd_ready_o,
  input  pstpa_pkg::cmd_t                       cmd_i,
  input  logic [WalkW-1:0]                      cmd_idx_a_i,
  input  logic [WalkW-1:0]                      cmd_idx_b_i,
  output pstpa_pkg::status_t                    status_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [pstpa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int AddrW   = $clog2(SIZE);

  localparam logic [WalkW-1:0] SizeW   = WalkW'(SIZE);
  localparam logic [AddrW-1:0] LastAdr = AddrW'(SIZE - 1);

  typedef logic [pstpa_pkg::DATA_W-1:0] word_t;

  pstpa_pkg::state_e state_q, state_d;
  logic [WalkW-1:0]  idx_q, idx_d, idx_b_q, idx_b_d, low_bit;
  logic [AddrW-1:0]  clr_q, clr_d, wb_addr_q, wb_addr_d, idx_addr;
  word_t             delta_q, delta_d, acc_q, acc_d, out_q, out_d;
  logic              pend_q, pend_d, sub_q, sub_d, lo_q, lo_d;
  logic              out_valid_q, out_valid_d, out_free;

  logic              wr_en, rd_en;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  word_t             wr_data, rd_data;

  pstpa_ram #(
    .WIDTH (pstpa_pkg::DATA_W),
    .DEPTH (SIZE)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign low_bit  = idx_q & (~idx_q + WalkW'(1));
  assign idx_addr = AddrW'(idx_q - WalkW'(1));
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign status_o.clearing = (state_q == pstpa_pkg::ST_CLEAR);
  assign cmd_ready_o       = (state_q == pstpa_pkg::ST_IDLE);
  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    idx_b_d     = idx_b_q;
    clr_d       = clr_q;
    wb_addr_d   = wb_addr_q;
    delta_d     = delta_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    sub_d       = sub_q;
    lo_d        = lo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    wr_en       = 1'b0;
    wr_addr     = clr_q;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = idx_addr;

    unique case (state_q)
      pstpa_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + AddrW'(1);
        if (clr_q == LastAdr) begin
          state_d = pstpa_pkg::ST_IDLE;
        end
      end
      pstpa_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          idx_d   = cmd_idx_a_i;
          idx_b_d = cmd_idx_b_i;
          delta_d = cmd_i.delta;
          acc_d   = '0;
          lo_d    = 1'b0;
          state_d = (cmd_i.kind == pstpa_pkg::KIND_ADD) ? pstpa_pkg::ST_ADD
                                                        : pstpa_pkg::ST_QUERY;
        end
      end
      pstpa_pkg::ST_ADD: begin
        // write back the entry read last cycle while reading the next one
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = wb_addr_q;
          wr_data = rd_data + delta_q;
        end
        if ((idx_q != '0) && (idx_q <= SizeW)) begin
          rd_en     = 1'b1;
          wb_addr_d = idx_addr;
          idx_d     = idx_q + low_bit;
          pend_d    = 1'b1;
        end else if (!pend_q) begin
          state_d = pstpa_pkg::ST_IDLE;
        end
      end
      pstpa_pkg::ST_QUERY: begin
        // upper prefix is added, lower prefix subtracted
        if (pend_q) begin
          acc_d = sub_q ? acc_q - rd_data : acc_q + rd_data;
        end
        if (idx_q != '0) begin
          rd_en  = 1'b1;
          idx_d  = idx_q - low_bit;
          pend_d = 1'b1;
          sub_d  = lo_q;
        end else if (!lo_q) begin
          lo_d  = 1'b1;
          idx_d = idx_b_q;
        end else if (!pend_q) begin
          state_d = pstpa_pkg::ST_OUT;
        end
      end
      pstpa_pkg::ST_OUT: begin
        if (out_free) begin
          out_d       = acc_q;
          out_valid_d = 1'b1;
          state_d     = pstpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pstpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pstpa_pkg::ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    idx_b_q   <= idx_b_d;
    wb_addr_q <= wb_addr_d;
    delta_q   <= delta_d;
    acc_q     <= acc_d;
    sub_q     <= sub_d;
    lo_q      <= lo_d;
    out_q     <= out_d;
  end

endmodule

>>> hdl/prefix_sum_tree_point_add_range_sum.sv
// An add walks a chain of up to log2(SIZE)+1 store entries; a query walks the chains
// of right and of left-1 and subtracts the second sum from the first.
// One item per walk: the back end takes a new item only once the last is through;
// the pace is set by the single read port of the partial-sum store, used at most once a cycle.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes each of the SIZE
// store entries, and no item is taken until it ends.
// ----------------------------------------------------------------------------
// prefix_sum_tree_point_add_range_sum: binary indexed tree top level
// Point add and range sum over SIZE 64-bit partial sums, wrapping mod 2^64.
// ----------------------------------------------------------------------------
module prefix_sum_tree_point_add_range_sum #(
  parameter int SIZE = pstpa_pkg::DEFAULT_SIZE
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata, lowest bit up: position[11], delta[64], range_left[11],
  // range_right[11], zero fill[7]
  input  logic [pstpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // tuser: func (0 add, 1 range query)
  input  logic                               s_axis_tuser_i,
  // Result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: range_total[64]
  output logic [pstpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  // Walk index holds a position plus one carry bit so an upward walk can
  // step past SIZE before it stops.
  localparam int IdxBits = $clog2(SIZE + 1);
  localparam int WalkW   = ((IdxBits > pstpa_pkg::POS_W) ? IdxBits : pstpa_pkg::POS_W) + 1;

  logic               cmd_valid, cmd_ready;
  pstpa_pkg::cmd_t    cmd;
  logic [WalkW-1:0]   cmd_idx_a, cmd_idx_b;
  pstpa_pkg::status_t status;

  // Front: take items, drop adds that touch no position, saturate query
  // bounds to SIZE, and hold up to two commands.
  pstpa_front #(
    .SIZE (SIZE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .status_i        (status),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd),
    .cmd_idx_a_o     (cmd_idx_a),
    .cmd_idx_b_o     (cmd_idx_b)
  );

  // Back: walk the tree; results park in an output register so the engine
  // moves on only once the previous result has a place to go.
  pstpa_back #(
    .SIZE (SIZE)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .cmd_idx_a_i     (cmd_idx_a),
    .cmd_idx_b_i     (cmd_idx_b),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

>>> hdl/pstpa_checker.sv
// ----------------------------------------------------------------------------
// pstpa_checker: port-level checks for the prefix-sum tree
// Tracks outstanding queries and checks results against them.
// ----------------------------------------------------------------------------
module pstpa_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid_i,
  input logic                               s_axis_tready_o,
  input logic                               s_axis_tuser_i,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [pstpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  logic [3:0] open_q, open_d;
  logic       q_in, r_out;

  assign q_in  = s_axis_tvalid_i && s_axis_tready_o
                 && (s_axis_tuser_i == pstpa_pkg::KIND_QUERY);
  assign r_out = m_axis_tvalid_o && m_axis_tready_i;

  always_comb begin
    open_d = open_q + 4'(q_in) - 4'(r_out);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  // A result only follows a query that has not yet been answered
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (open_q != '0))
    else $error("result without an open query");

  // Queue, engine and output register bound the open queries
  a_open_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'd4)
    else $error("too many open queries");

  // The store is being cleared right after reset: no intake
  a_clear_blocks_intake: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready_o)
    else $error("item taken during clearing pass");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind prefix_sum_tree_point_add_range_sum pstpa_checker u_pstpa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
